FILE: hdl/go_back_n_sender_window_unit_defines.svh
// assertion macros shared by the go-back-n sender window modules
`ifndef GO_BACK_N_SENDER_WINDOW_UNIT_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_UNIT_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define GBN_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define GBN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/gbn_pkg.sv
// shared types, constants and helpers of the go-back-n sender window
`timescale 1ns / 1ps
`default_nettype none
package gbn_pkg;

    localparam int MAX_WINDOW  = 8;
    localparam int SEQ_BITS    = 16;
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int QUEUE_DEPTH = 2;

    // fixed field widths on the ports
    localparam int WIN_REG_W   = 4;
    localparam int TOTAL_W     = 16;
    localparam int ACK_W       = 16;
    localparam int OP_W        = 2;
    localparam int SEQ_FIELD_W = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int CMP_W       = (SEQ_BITS > ACK_W) ? SEQ_BITS : ACK_W;

    localparam logic [TOTAL_W:0] SEQ_MAX_CAP =
        (SEQ_BITS >= TOTAL_W) ? {1'b0, {TOTAL_W{1'b1}}}
                              : (TOTAL_W + 1)'((64'd1 << SEQ_BITS) - 64'd1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 1'b1;

    // reset values of the configuration registers
    localparam logic [WIN_REG_W-1:0] WINDOW_RESET = 4'd4;
    localparam logic [TOTAL_W-1:0]   TOTAL_RESET  = 16'd10;

    typedef logic [SEQ_BITS-1:0] t_seq;
    typedef logic [CNT_W-1:0]    t_cnt;

    typedef enum logic [OP_W-1:0] {
        OP_START   = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        ACK_OK     = 2'd0,
        ACK_STALE  = 2'd1,
        ACK_BEYOND = 2'd2
    } t_ack_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_SIZE,
        ST_EMIT
    } t_back_state;

    // classified event handed from front to back
    typedef struct packed {
        logic        timeout;
        t_ack_status status;
        logic        done;
        t_seq        base;
    } t_cmd;

    // back-end status seen by the front end
    typedef struct packed {
        logic busy;
        t_seq next_seq;
    } t_back_status;

    // one result beat
    typedef struct packed {
        logic        send_valid;
        t_seq        seq_number;
        logic        is_resend;
        t_ack_status ack_status;
        logic        all_done;
        logic        last;
    } t_result;

    // window register value mapped into 1 .. MAX_WINDOW
    function automatic t_cnt eff_window(input logic [WIN_REG_W-1:0] w);
        t_cnt r;
        if (w == '0) begin
            r = t_cnt'(1);
        end else if (32'(w) > MAX_WINDOW) begin
            r = t_cnt'(MAX_WINDOW);
        end else begin
            r = t_cnt'(w);
        end
        return r;
    endfunction

    // total count capped so every number fits the sequence width
    function automatic t_seq eff_total(input logic [TOTAL_W-1:0] t);
        t_seq r;
        if ({1'b0, t} > SEQ_MAX_CAP) begin
            r = t_seq'(SEQ_MAX_CAP);
        end else begin
            r = t_seq'(t);
        end
        return r;
    endfunction

    // clamp a span to at most one full window
    function automatic t_cnt clamp_cnt(input logic [SEQ_BITS:0] v);
        t_cnt r;
        if (v > (SEQ_BITS + 1)'(MAX_WINDOW)) begin
            r = t_cnt'(MAX_WINDOW);
        end else begin
            r = t_cnt'(v);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/go_back_n_sender_window_unit.sv
// top level of the go-back-n sender window: config registers, front end, queue, sequencer
//
//  channel   dir  handshake                   payload
//  events    in   i_s_tvalid / o_s_tready     tdata: ack_number; tuser: opcode
//  results   out  o_m_tvalid / i_m_tready     tdata: result flags and number; tlast: last
//  config    in   i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// an event passes the front register, then the queue, then the sequencer, which sizes
// the burst of n = 1 .. 8 results in its PREP and SIZE states, then sends one beat per
// cycle from its output register while i_m_tready is high.
// the next event is taken once the sequencer is idle, while the last beat may still wait.
// synchronous active-low reset clears base and next sequence, window 4, total 10.
// a low i_m_tready holds the sequencer on the current beat.
`timescale 1ns / 1ps
`default_nettype none
module go_back_n_sender_window_unit (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // event beat
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire  [15:0]                         i_s_tdata,   // [15:0] ack_number
    input  wire  [1:0]                          i_s_tuser,   // [1:0] opcode
    // result beat
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    output logic [23:0]                         o_m_tdata,   // [0] send_valid, [16:1] seq_number,
                                                             // [17] is_resend, [19:18] ack_status,
                                                             // [20] all_done, [23:21] zero
    output logic                                o_m_tlast,
    // configuration write
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [gbn_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire  [gbn_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import gbn_pkg::*;

    logic [WIN_REG_W-1:0] r_window;
    logic [TOTAL_W-1:0]   r_total;
    t_cnt                 win_eff;
    t_seq                 total_eff;
    t_back_status         back_status;
    t_cmd                 push_cmd, pop_cmd;
    logic                 push, pop, queue_empty, queue_full;
    t_result              result;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
            r_total  <= TOTAL_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WINDOW_SIZE:   r_window <= i_cfg_data[WIN_REG_W-1:0];
                CFG_TOTAL_PACKETS: r_total  <= i_cfg_data[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    assign win_eff   = eff_window(r_window);
    assign total_eff = eff_total(r_total);

    // event front end
    gbn_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tvalid      (i_s_tvalid),
        .o_tready      (o_s_tready),
        .i_ack         (i_s_tdata),
        .i_opcode      (i_s_tuser),
        .i_back        (back_status),
        .i_total       (total_eff),
        .i_queue_empty (queue_empty),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // command queue
    gbn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (pop_cmd),
        .o_empty (queue_empty),
        .o_full  (queue_full)
    );

    // send sequencer
    gbn_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (queue_empty),
        .o_pop         (pop),
        .i_cmd         (pop_cmd),
        .i_window      (win_eff),
        .i_total       (total_eff),
        .o_status      (back_status),
        .o_tvalid      (o_m_tvalid),
        .i_tready      (i_m_tready),
        .o_result      (result)
    );

    // result beat packing
    assign o_m_tdata = {3'b000,
                        result.all_done,
                        result.ack_status,
                        result.is_resend,
                        SEQ_FIELD_W'(result.seq_number),
                        result.send_valid};
    assign o_m_tlast = result.last;

endmodule
`default_nettype wire

FILE: hdl/gbn_queue.sv
// short command queue between the event front end and the send sequencer
`timescale 1ns / 1ps
`default_nettype none
module gbn_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  gbn_pkg::t_cmd     i_data,
    input  wire               i_pop,
    output gbn_pkg::t_cmd     o_data,
    output logic              o_empty,
    output logic              o_full
);
    import gbn_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              do_push, do_pop;

    assign o_empty = (r_fill == '0);
    assign o_full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and fill update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    // entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/gbn_front.sv
// event front end: takes events, classifies acks and keeps the window base
`timescale 1ns / 1ps
`default_nettype none
`include "go_back_n_sender_window_unit_defines.svh"
module gbn_front (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_tvalid,
    output logic                                o_tready,
    input  wire  [gbn_pkg::ACK_W-1:0]           i_ack,
    input  wire  [gbn_pkg::OP_W-1:0]            i_opcode,
    input  gbn_pkg::t_back_status               i_back,
    input  gbn_pkg::t_seq                       i_total,
    input  wire                                 i_queue_empty,
    output logic                                o_push,
    output gbn_pkg::t_cmd                       o_cmd
);
    import gbn_pkg::*;

    logic        r_cmd_valid;
    t_cmd        r_cmd, n_cmd;
    t_seq        r_base, n_base;
    logic        accept;
    logic [CMP_W-1:0] ack_w, next_w, base_w;

    // one event in flight: wait for queue and sequencer to drain
    assign o_tready = !r_cmd_valid && i_queue_empty && !i_back.busy;
    assign accept   = i_tvalid && o_tready;
    assign o_push   = r_cmd_valid;
    assign o_cmd    = r_cmd;

    assign ack_w  = CMP_W'(i_ack);
    assign next_w = CMP_W'(i_back.next_seq);
    assign base_w = CMP_W'(r_base);

    // ack classification and base move
    always_comb begin
        n_base         = r_base;
        n_cmd.status   = ACK_OK;
        n_cmd.timeout  = (i_opcode == OP_TIMEOUT);
        if (i_opcode == OP_ACK) begin
            if (ack_w >= next_w) begin
                n_cmd.status = ACK_BEYOND;
            end else if (ack_w < base_w) begin
                n_cmd.status = ACK_STALE;
            end else begin
                n_base = t_seq'(i_ack) + 1'b1;
            end
        end
        n_cmd.base = n_base;
        n_cmd.done = (n_base >= i_total);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_base      <= '0;
        end else if (accept) begin
            r_cmd_valid <= 1'b1;
            r_base      <= n_base;
        end else begin
            r_cmd_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    // checks
    `GBN_ASSERT_NEXT(a_ack_moves_base, accept && i_opcode == OP_ACK && ack_w < next_w && ack_w >= base_w, r_base == $past(t_seq'(i_ack)) + 1'b1, "accepted ack did not move base")
    `GBN_ASSERT_SAME(a_base_not_past_next, !i_back.busy, r_base <= i_back.next_seq, "window base beyond next sequence")
    `GBN_ASSERT_SAME(a_push_into_empty, r_cmd_valid, i_queue_empty && !i_back.busy, "command pushed while back end busy")

endmodule
`default_nettype wire

FILE: hdl/gbn_back.sv
// send sequencer: sizes each event's burst and emits resends and fresh sends
`timescale 1ns / 1ps
`default_nettype none
`include "go_back_n_sender_window_unit_defines.svh"
module gbn_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_queue_empty,
    output logic                   o_pop,
    input  gbn_pkg::t_cmd          i_cmd,
    input  gbn_pkg::t_cnt          i_window,
    input  gbn_pkg::t_seq          i_total,
    output gbn_pkg::t_back_status  o_status,
    output logic                   o_tvalid,
    input  wire                    i_tready,
    output gbn_pkg::t_result       o_result
);
    import gbn_pkg::*;

    t_back_state r_state, n_state;
    t_seq        r_next, n_next;
    t_cmd        r_cmd;
    t_cnt        r_resend_n, r_lim_w, r_lim_t, r_n, r_k, n_k;
    logic        r_empty;
    logic        r_out_valid, n_out_valid;
    t_result     r_out, n_out;
    logic        load_out, slot_free, is_last;

    // sizing terms
    t_seq              diff;
    logic [SEQ_BITS:0] end_w, span_w;
    t_seq              span_t;
    t_cnt              room, fill, lim_min, sum;

    assign o_tvalid        = r_out_valid;
    assign o_result        = r_out;
    assign o_status.busy   = (r_state != ST_IDLE);
    assign o_status.next_seq = r_next;
    assign slot_free       = !r_out_valid || i_tready;

    // burst limits from the event
    assign diff   = r_next - r_cmd.base;
    assign end_w  = {1'b0, r_cmd.base} + (SEQ_BITS + 1)'(i_window);
    assign span_w = end_w - {1'b0, r_next};
    assign span_t = i_total - r_next;

    // fill count from limits
    assign room    = t_cnt'(MAX_WINDOW) - r_resend_n;
    assign lim_min = (r_lim_w < r_lim_t) ? r_lim_w : r_lim_t;
    assign fill    = (lim_min < room) ? lim_min : room;
    assign sum     = r_resend_n + fill;
    assign is_last = r_empty || (r_k == r_n - 1'b1);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_next      = r_next;
        n_k         = r_k;
        o_pop       = 1'b0;
        load_out    = 1'b0;
        n_out       = r_out;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_queue_empty) begin
                    o_pop   = 1'b1;
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_SIZE;
            end
            ST_SIZE: begin
                n_k     = '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (slot_free) begin
                    load_out         = 1'b1;
                    n_out.ack_status = r_cmd.status;
                    n_out.all_done   = r_cmd.done;
                    n_out.last       = is_last;
                    if (r_empty) begin
                        n_out.send_valid = 1'b0;
                        n_out.seq_number = '0;
                        n_out.is_resend  = 1'b0;
                    end else if (r_k < r_resend_n) begin
                        n_out.send_valid = 1'b1;
                        n_out.seq_number = r_cmd.base + t_seq'(r_k);
                        n_out.is_resend  = 1'b1;
                    end else begin
                        n_out.send_valid = 1'b1;
                        n_out.seq_number = r_next;
                        n_out.is_resend  = 1'b0;
                        n_next           = r_next + 1'b1;
                    end
                    n_k = r_k + 1'b1;
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_next      <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next      <= n_next;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // event latch, sizing and result payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == ST_PREP) begin
            r_resend_n <= r_cmd.timeout ? clamp_cnt({1'b0, diff}) : '0;
            r_lim_w    <= ({1'b0, r_next} < end_w) ? clamp_cnt(span_w) : '0;
            r_lim_t    <= (r_next < i_total) ? clamp_cnt({1'b0, span_t}) : '0;
        end
        if (r_state == ST_SIZE) begin
            r_n     <= sum;
            r_empty <= (sum == '0);
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    // checks
    `GBN_ASSERT_SAME(a_burst_in_range, r_state == ST_EMIT && !r_empty, r_k < r_n, "emit index past burst length")
    `GBN_ASSERT_SAME(a_burst_bounded, r_state == ST_EMIT, r_n <= t_cnt'(MAX_WINDOW), "burst longer than one window")
    `GBN_ASSERT_NEXT(a_fresh_bumps_next, r_state == ST_EMIT && slot_free && !r_empty && r_k >= r_resend_n, r_next == $past(r_next) + 1'b1, "fresh send did not advance next sequence")

endmodule
`default_nettype wire
